@@ rtl/vlrm_pkg.sv @@
// Shared types and constants of the video level range monitor.
package vlrm_pkg;

  localparam int NUM_CH     = 3;
  localparam int LEVELS     = 256;
  localparam int LEVEL_W    = 8;
  localparam int CNT_W      = 25;
  localparam int FRAME_W    = 32;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Crop is w / 20, done as a multiply by a reciprocal and a shift.
  localparam int DIM_MIN    = 20;
  localparam int CROP_RECIP = 52429;
  localparam int CROP_SHIFT = 20;

  localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 13'd720;
  localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 13'd576;
  localparam logic [LEVEL_W-1:0] RST_OVER_LIMIT   = 8'd235;
  localparam logic [LEVEL_W-1:0] RST_OVER_LIMIT1  = 8'd240;
  localparam logic [LEVEL_W-1:0] RST_UNDER_LIMIT  = 8'd16;
  localparam logic [LEVEL_W-1:0] VALLEY_INIT      = 8'd255;

  localparam logic REPORT_FRAME = 1'b0;
  localparam logic REPORT_HIST  = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PIXEL_FORMAT = 3'd2,
    CFG_OVER_LIMIT   = 3'd3,
    CFG_OVER_LIMIT1  = 3'd4,
    CFG_UNDER_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                          kind;
    logic [FRAME_W-1:0]                 frame_number;
    logic [LEVEL_W-1:0]                 bin;
    logic [NUM_CH-1:0][CNT_W-1:0]       over;
    logic [NUM_CH-1:0][CNT_W-1:0]       under;
    logic [NUM_CH-1:0][LEVEL_W-1:0]     peak;
    logic [NUM_CH-1:0][LEVEL_W-1:0]     valley;
  } cmd_t;

endpackage

@@ rtl/vlrm_if.sv @@
// Handshake interfaces for the input items and the result beats.
interface vlrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] sample;
  logic [7:0] bin_index;
  modport source (output valid, opcode, sample, bin_index, input ready);
  modport sink (input valid, opcode, sample, bin_index, output ready);
endinterface

interface vlrm_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [1:0]  channel;
  logic [31:0] frame_number;
  logic [24:0] over_count;
  logic [24:0] under_count;
  logic [7:0]  peak_level;
  logic [7:0]  valley_level;
  logic [31:0] peak_hist_count;
  logic [31:0] valley_hist_count;
  logic        last;
  modport source (output valid, report_kind, channel, frame_number, over_count,
                  under_count, peak_level, valley_level, peak_hist_count,
                  valley_hist_count, last, input ready);
  modport sink (input valid, report_kind, channel, frame_number, over_count,
                under_count, peak_level, valley_level, peak_hist_count,
                valley_hist_count, last, output ready);
endinterface

@@ rtl/vlrm_cmd_fifo.sv @@
// Short command queue between the front and the back.
module vlrm_cmd_fifo
  import vlrm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  assign cmd_o   = mem_q[rd_q];
  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("command queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ rtl/vlrm_front.sv @@
// Front part: takes input items, tracks frame position and running statistics.
module vlrm_front
  import vlrm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vlrm_in_if.sink              item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 init_done_i,
  input  logic                 full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]   fw_q, fh_q;
  logic               yuv_q;
  logic [LEVEL_W-1:0] ol_q, ol1_q, ul_q;
  logic               cfg_we_q;

  // Plane geometry, registered from the configuration.
  logic [DW-1:0] lpw_q, lx0_q, lx1_q, cpw_q, cx0_q, cx1_q;
  logic [HW-1:0] lph_q, ly0_q, ly1_q, cph_q, cy0_q, cy1_q;
  logic [CFG_W:0] wc, hc;
  logic [DW-1:0]  w_d, offx_d;
  logic [HW-1:0]  h_d, offy_d;
  logic [CFG_W+16:0] prodx, prody;

  always_comb begin
    wc = {1'b0, fw_q};
    if (wc < (CFG_W+1)'(DIM_MIN)) begin
      wc = (CFG_W+1)'(DIM_MIN);
    end else if (wc > (CFG_W+1)'(MAX_WIDTH)) begin
      wc = (CFG_W+1)'(MAX_WIDTH);
    end
    hc = {1'b0, fh_q};
    if (hc < (CFG_W+1)'(DIM_MIN)) begin
      hc = (CFG_W+1)'(DIM_MIN);
    end else if (hc > (CFG_W+1)'(MAX_HEIGHT)) begin
      hc = (CFG_W+1)'(MAX_HEIGHT);
    end
    w_d    = wc[DW-1:0];
    h_d    = hc[HW-1:0];
    prodx  = (CFG_W+17)'(wc) * (CFG_W+17)'(CROP_RECIP);
    prody  = (CFG_W+17)'(hc) * (CFG_W+17)'(CROP_RECIP);
    offx_d = DW'(prodx >> CROP_SHIFT);
    offy_d = HW'(prody >> CROP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    lpw_q <= w_d;
    lx0_q <= offx_d;
    lx1_q <= w_d - offx_d;
    cpw_q <= w_d >> 1;
    cx0_q <= offx_d >> 1;
    cx1_q <= (w_d - offx_d) >> 1;
    lph_q <= h_d;
    ly0_q <= offy_d;
    ly1_q <= h_d - offy_d;
    cph_q <= h_d >> 1;
    cy0_q <= offy_d >> 1;
    cy1_q <= (h_d - offy_d) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= RST_FRAME_WIDTH;
      fh_q     <= RST_FRAME_HEIGHT;
      yuv_q    <= 1'b0;
      ol_q     <= RST_OVER_LIMIT;
      ol1_q    <= RST_OVER_LIMIT1;
      ul_q     <= RST_UNDER_LIMIT;
      cfg_we_q <= 1'b1;
    end else begin
      cfg_we_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  fw_q  <= cfg_data_i;
          CFG_FRAME_HEIGHT: fh_q  <= cfg_data_i;
          CFG_PIXEL_FORMAT: yuv_q <= cfg_data_i[0];
          CFG_OVER_LIMIT:   ol_q  <= cfg_data_i[LEVEL_W-1:0];
          CFG_OVER_LIMIT1:  ol1_q <= cfg_data_i[LEVEL_W-1:0];
          CFG_UNDER_LIMIT:  ul_q  <= cfg_data_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // The geometry registers are loaded from the registered configuration, so they lag a configuration write.
  logic accept;
  assign item_i.ready = init_done_i && !full_i && !cfg_we_i && !cfg_we_q;
  assign accept       = item_i.valid && item_i.ready;

  logic [DW-1:0]  col_q, col_d;
  logic [HW-1:0]  row_q, row_d;
  logic [1:0]     phase_q, phase_d;
  logic [FRAME_W-1:0] frames_q, frames_d;
  logic [NUM_CH-1:0][CNT_W-1:0]   over_q, over_d, under_q, under_d;
  logic [NUM_CH-1:0][LEVEL_W-1:0] peak_q, peak_d, valley_q, valley_d;

  logic          chroma, inwin, frame_end;
  logic [DW-1:0] pw, x0, x1;
  logic [HW-1:0] ph, y0, y1;
  logic [DW:0]   col_inc;
  logic [HW:0]   row_inc;
  logic [LEVEL_W-1:0] lim;
  logic [1:0]    ch;

  always_comb begin
    ch      = phase_q;
    chroma  = yuv_q && (ch != 2'd0);
    pw      = chroma ? cpw_q : lpw_q;
    x0      = chroma ? cx0_q : lx0_q;
    x1      = chroma ? cx1_q : lx1_q;
    ph      = chroma ? cph_q : lph_q;
    y0      = chroma ? cy0_q : ly0_q;
    y1      = chroma ? cy1_q : ly1_q;
    lim     = (yuv_q && ch == 2'd1) ? ol1_q : ol_q;
    inwin   = (col_q >= x0) && (col_q < x1) && (row_q >= y0) && (row_q < y1);
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;

    col_d     = col_q;
    row_d     = row_q;
    phase_d   = phase_q;
    frames_d  = frames_q;
    over_d    = over_q;
    under_d   = under_q;
    peak_d    = peak_q;
    valley_d  = valley_q;
    frame_end = 1'b0;
    push_o    = 1'b0;

    cmd_o              = '0;
    cmd_o.kind         = CMD_READ;
    cmd_o.frame_number = frames_q;
    cmd_o.bin          = item_i.bin_index;

    if (accept) begin
      if (item_i.opcode == OP_READ) begin
        push_o = 1'b1;
      end else if (item_i.opcode == OP_CLEAR) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_CLEAR;
        frames_d   = '0;
      end else if (item_i.opcode == OP_BYTE) begin
        if (inwin) begin
          if (item_i.sample > lim) begin
            over_d[ch] = over_q[ch] + 1'b1;
          end
          if (item_i.sample < ul_q) begin
            under_d[ch] = under_q[ch] + 1'b1;
          end
          if (item_i.sample > peak_q[ch]) begin
            peak_d[ch] = item_i.sample;
          end
          if (item_i.sample < valley_q[ch]) begin
            valley_d[ch] = item_i.sample;
          end
        end
        if (!yuv_q) begin
          if (phase_q == 2'd2) begin
            phase_d = 2'd0;
            col_d   = col_inc[DW-1:0];
            if (col_inc >= {1'b0, pw}) begin
              col_d = '0;
              row_d = row_inc[HW-1:0];
              if (row_inc >= {1'b0, ph}) begin
                row_d     = '0;
                frame_end = 1'b1;
              end
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end else begin
          col_d = col_inc[DW-1:0];
          if (col_inc >= {1'b0, pw}) begin
            col_d = '0;
            row_d = row_inc[HW-1:0];
            if (row_inc >= {1'b0, ph}) begin
              row_d = '0;
              if (phase_q == 2'd2) begin
                phase_d   = 2'd0;
                frame_end = 1'b1;
              end else begin
                phase_d = phase_q + 1'b1;
              end
            end
          end
        end
        if (frame_end) begin
          push_o             = 1'b1;
          frames_d           = frames_q + 1'b1;
          cmd_o.kind         = CMD_FRAME;
          cmd_o.frame_number = frames_d;
          cmd_o.over         = over_d;
          cmd_o.under        = under_d;
          cmd_o.peak         = peak_d;
          cmd_o.valley       = valley_d;
          over_d             = '0;
          under_d            = '0;
          peak_d             = '0;
          valley_d           = {NUM_CH{VALLEY_INIT}};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      phase_q  <= '0;
      frames_q <= '0;
      over_q   <= '0;
      under_q  <= '0;
      peak_q   <= '0;
      valley_q <= {NUM_CH{VALLEY_INIT}};
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      phase_q  <= phase_d;
      frames_q <= frames_d;
      over_q   <= over_d;
      under_q  <= under_d;
      peak_q   <= peak_d;
      valley_q <= valley_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("channel phase out of range");
  a_push_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("command pushed into a full queue");
  a_frame_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.kind == CMD_FRAME) |=> (col_q == '0 && row_q == '0 && phase_q == '0))
    else $error("frame end did not restart position");

endmodule

@@ rtl/vlrm_back.sv @@
// Back part: histogram memories, clearing pass and result beats.
module vlrm_back
  import vlrm_pkg::*;
#(
  parameter int HIST_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_pop_o,
  output logic     init_done_o,
  vlrm_out_if.source result_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPDATE, S_EMIT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic [1:0]         k_q;
  logic [LEVEL_W-1:0] sweep_q;
  logic               init_done_q;

  logic [HIST_BITS-1:0] pk_mem [NUM_CH][LEVELS];
  logic [HIST_BITS-1:0] vl_mem [NUM_CH][LEVELS];
  logic [HIST_BITS-1:0] pk_rd_q [NUM_CH];
  logic [HIST_BITS-1:0] vl_rd_q [NUM_CH];

  logic [LEVEL_W-1:0]   pk_addr [NUM_CH];
  logic [LEVEL_W-1:0]   vl_addr [NUM_CH];
  logic [HIST_BITS-1:0] pk_wd [NUM_CH];
  logic [HIST_BITS-1:0] vl_wd [NUM_CH];
  logic                 mem_we, rd_en;

  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_UPDATE);
  assign rd_en     = (state_q == S_READ);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (state_q == S_CLEAR) begin
        pk_addr[k] = sweep_q;
        vl_addr[k] = sweep_q;
        pk_wd[k]   = '0;
        vl_wd[k]   = '0;
      end else begin
        pk_addr[k] = (cmd_q.kind == CMD_READ) ? cmd_q.bin : cmd_q.peak[k];
        vl_addr[k] = (cmd_q.kind == CMD_READ) ? cmd_q.bin : cmd_q.valley[k];
        // Counts stop at the all-ones value.
        pk_wd[k]   = (&pk_rd_q[k]) ? pk_rd_q[k] : pk_rd_q[k] + 1'b1;
        vl_wd[k]   = (&vl_rd_q[k]) ? vl_rd_q[k] : vl_rd_q[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (mem_we) begin
        pk_mem[k][pk_addr[k]] <= pk_wd[k];
        vl_mem[k][vl_addr[k]] <= vl_wd[k];
      end
      if (rd_en) begin
        pk_rd_q[k] <= pk_mem[k][pk_addr[k]];
        vl_rd_q[k] <= vl_mem[k][vl_addr[k]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      k_q         <= '0;
      init_done_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == LEVEL_W'(LEVELS - 1)) begin
            state_q     <= S_IDLE;
            init_done_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            sweep_q <= '0;
            state_q <= (cmd_i.kind == CMD_CLEAR) ? S_CLEAR : S_READ;
          end
        end
        S_READ: begin
          k_q     <= '0;
          state_q <= (cmd_q.kind == CMD_FRAME) ? S_UPDATE : S_EMIT;
        end
        S_UPDATE: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (result_o.ready) begin
            if (k_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  logic [31:0] pk_rd32, vl_rd32;
  if (HIST_BITS > 32) begin : g_sat
    assign pk_rd32 = (|pk_rd_q[k_q][HIST_BITS-1:32]) ? '1 : pk_rd_q[k_q][31:0];
    assign vl_rd32 = (|vl_rd_q[k_q][HIST_BITS-1:32]) ? '1 : vl_rd_q[k_q][31:0];
  end else begin : g_ext
    assign pk_rd32 = 32'(pk_rd_q[k_q]);
    assign vl_rd32 = 32'(vl_rd_q[k_q]);
  end

  logic is_read;
  assign is_read = (cmd_q.kind == CMD_READ);

  assign init_done_o               = init_done_q;
  assign result_o.valid             = (state_q == S_EMIT);
  assign result_o.report_kind       = is_read ? REPORT_HIST : REPORT_FRAME;
  assign result_o.channel           = k_q;
  assign result_o.frame_number      = cmd_q.frame_number;
  assign result_o.over_count        = is_read ? '0 : cmd_q.over[k_q];
  assign result_o.under_count       = is_read ? '0 : cmd_q.under[k_q];
  assign result_o.peak_level        = is_read ? '0 : cmd_q.peak[k_q];
  assign result_o.valley_level      = is_read ? '0 : cmd_q.valley[k_q];
  assign result_o.peak_hist_count   = is_read ? pk_rd32 : '0;
  assign result_o.valley_hist_count = is_read ? vl_rd32 : '0;
  assign result_o.last              = (k_q == 2'd2);

  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o) else $error("command taken during clear");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && k_q == 2'd2) |=> (state_q == S_IDLE))
    else $error("result run did not end after the last beat");
  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (k_q != 2'd3)) else $error("result channel out of range");

endmodule

@@ rtl/video_level_range_monitor_top.sv @@
// Top level of the video level range monitor.
// Input channel item_i carries one item per beat: a frame byte (RGB24 or
// planar YUV420, in memory order), a histogram bin read, or a statistics clear.
// Frame bytes are taken one per cycle while item_i.ready is high. The front
// tracks frame position and per-channel statistics; commands pass through a
// four-entry queue to the back. At the last byte of a frame three report beats
// leave on result_o after the queue and the back's read and update states; a
// bin read likewise gives three beats after the queue and the read state. Each
// frame or read command holds the back while it leaves the queue, for histogram
// memory access and for its three beats; a clear holds it while the histogram
// memories are swept to zero. After reset a sweep clears all 256 bins and
// item_i.ready stays low; configuration writes are taken at any time. Ready
// also drops while a configuration write is made and the plane geometry is
// recomputed. When the receiver stalls, the back holds its beat and the queue
// fills; once it is full, item_i.ready drops until the back takes a command.
module video_level_range_monitor_top
  import vlrm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int HIST_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vlrm_in_if.sink              item_i,
  vlrm_out_if.source           result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic push, pop, full, empty, init_done;
  cmd_t cmd_in, cmd_out;

  vlrm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .init_done_i (init_done),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  vlrm_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  vlrm_back #(
    .HIST_BITS (HIST_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!empty),
    .cmd_pop_o   (pop),
    .init_done_o (init_done),
    .result_o    (result_o)
  );

endmodule
